/* rtl/mrp_pkg.sv */
package mrp_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

  localparam int MODE_W    = 2;
  localparam int DIM_W     = 15;
  localparam int FMT_W     = 32;
  localparam int SLOT_W    = 4;
  localparam int FRAME_W   = 32;
  localparam int STATUS_W  = 3;
  localparam int OUT_IDX_W = 4;
  localparam int OUT_CNT_W = 5;
  localparam int TOTAL_W   = 32;
  localparam int LIMIT_W   = 5;
  localparam int IDLE_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_SEL_BIT = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
  localparam logic [IDLE_W-1:0]  IDLE_RESET  = 32'd60;

  localparam logic REG_POOL_LIMIT = 1'b0;
  localparam logic REG_IDLE_LIMIT = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ACQUIRE = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_CLEANUP = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_NEW      = 3'd1,
    ST_FULL     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_IGNORED  = 3'd4,
    ST_CLEANED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD    = 3'd0,
    OP_EVAL    = 3'd1,
    OP_ACQUIRE = 3'd2,
    OP_RELEASE = 3'd3,
    OP_SHIFT   = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [DIM_W-1:0]     width;
    logic [DIM_W-1:0]     height;
    logic [FMT_W-1:0]     fmt;
    logic [FRAME_W-1:0]   frame;
    logic [IDLE_W-1:0]    idle_limit;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [FMT_W-1:0]   fmt;
    logic               busy;
    logic [FRAME_W-1:0] stamp;
    logic               kill;
  } entry_t;

endpackage

/* rtl/mrp_cell.sv */
module mrp_cell (
  input  logic            clk,
  input  mrp_pkg::cmd_t   cmd,
  input  logic            in_pool,
  input  logic            sel_wr,
  input  logic            hit_seen_in,
  input  logic            hole_seen_in,
  input  mrp_pkg::entry_t nb_in,
  output mrp_pkg::entry_t ent_out,
  output logic            hit_seen_out,
  output logic            hole_seen_out
);
  import mrp_pkg::*;

  entry_t             ent_r, ent_nxt;
  logic               match_r, match_nxt;
  logic [FRAME_W-1:0] age;

  always_comb begin
    ent_nxt   = ent_r;
    match_nxt = match_r;
    age       = cmd.frame - ent_r.stamp;
    case (cmd.op)
      OP_EVAL: begin
        match_nxt = in_pool & ~ent_r.busy & (ent_r.width == cmd.width) &
                    (ent_r.height == cmd.height) & (ent_r.fmt == cmd.fmt);
        ent_nxt.kill = in_pool & ~ent_r.busy & (age > cmd.idle_limit);
      end
      OP_ACQUIRE: begin
        if (match_r & ~hit_seen_in) begin
          ent_nxt.busy  = 1'b1;
          ent_nxt.stamp = cmd.frame;
        end
        if (sel_wr) begin
          ent_nxt.width  = cmd.width;
          ent_nxt.height = cmd.height;
          ent_nxt.fmt    = cmd.fmt;
          ent_nxt.busy   = 1'b1;
          ent_nxt.stamp  = cmd.frame;
          ent_nxt.kill   = 1'b0;
        end
      end
      OP_RELEASE: begin
        if (sel_wr) begin
          ent_nxt.busy  = 1'b0;
          ent_nxt.stamp = cmd.frame;
        end
      end
      OP_SHIFT: begin
        // cells at and past the first hole take the right neighbor's entry
        if (hole_seen_in | ent_r.kill) begin
          ent_nxt = nb_in;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r   <= ent_nxt;
    match_r <= match_nxt;
  end

  assign ent_out       = ent_r;
  assign hit_seen_out  = hit_seen_in | match_r;
  assign hole_seen_out = hole_seen_in | ent_r.kill;

endmodule

/* rtl/matching_resource_pool_top.sv */
// Channel  | Ports                                  | Handshake
// input    | start, busy, in_*                      | accepted when start & !busy
// result   | out_valid, out_*                       | one-cycle strobe, no stall
// config   | psel, penable, pwrite, paddr, pwdata,  | APB write on access phase,
//          | prdata, pready                         | pready tied high
//
// Acquire and release: eval, acquire or release, then finish, then the out_valid strobe.
// Mode 3 skips the acquire/release phase: eval goes straight to finish.
// Cleanup removes R entries: cells at and past the first stale one shift left
// by one position per cycle until no entry idle past the idle limit is left.
// One word in flight; busy stays high until the result strobe cycle.
// Reset (synchronous, rst_n low) empties the pool, zeroes the statistics and
// restores both limits; entry contents are not cleared.
module matching_resource_pool_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [mrp_pkg::MODE_W-1:0]     in_mode,
  input  logic [mrp_pkg::DIM_W-1:0]      in_req_width,
  input  logic [mrp_pkg::DIM_W-1:0]      in_req_height,
  input  logic [mrp_pkg::FMT_W-1:0]      in_req_format,
  input  logic [mrp_pkg::SLOT_W-1:0]     in_slot,
  input  logic [mrp_pkg::FRAME_W-1:0]    in_frame_number,
  output logic                           out_valid,
  output logic [mrp_pkg::STATUS_W-1:0]   out_status,
  output logic [mrp_pkg::OUT_IDX_W-1:0]  out_slot_index,
  output logic [mrp_pkg::OUT_CNT_W-1:0]  out_entry_count,
  output logic [mrp_pkg::OUT_CNT_W-1:0]  out_busy_count,
  output logic [mrp_pkg::TOTAL_W-1:0]    out_acquire_total,
  output logic [mrp_pkg::TOTAL_W-1:0]    out_hit_total,
  output logic [mrp_pkg::OUT_CNT_W-1:0]  out_removed_count,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mrp_pkg::ADDR_W-1:0]     paddr,
  input  logic [mrp_pkg::DATA_W-1:0]     pwdata,
  output logic [mrp_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);
  import mrp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_ACQ, S_REL, S_SHIFT, S_FIN
  } state_t;

  state_t             state_r;
  logic [MODE_W-1:0]  mode_r;
  logic [DIM_W-1:0]   width_r, height_r;
  logic [FMT_W-1:0]   fmt_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [FRAME_W-1:0] frame_r;
  logic [CNT_W-1:0]   held_r, removed_r;
  logic [TOTAL_W-1:0] acq_r, hit_r;
  status_t            status_r;
  logic [IDX_W-1:0]   index_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [IDLE_W-1:0]  idle_r;

  logic                   out_valid_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [OUT_IDX_W-1:0]   out_index_r;
  logic [OUT_CNT_W-1:0]   out_entry_r, out_busy_r, out_removed_r;
  logic [TOTAL_W-1:0]     out_acq_r, out_hit_r;

  cmd_t                  cmd;
  entry_t                ent   [POOL_DEPTH];
  entry_t                nb    [POOL_DEPTH];
  logic [POOL_DEPTH:0]   hit_seen, hole_seen;
  logic [POOL_DEPTH-1:0] in_pool, sel_wr, first;
  logic                  hit_any, hole_any, room, slot_ok;
  logic [IDX_W-1:0]      hit_idx;
  logic [CNT_W-1:0]      eff_limit, busy_cnt;

  assign hit_seen[0]  = 1'b0;
  assign hole_seen[0] = 1'b0;
  assign hit_any      = hit_seen[POOL_DEPTH];
  assign hole_any     = hole_seen[POOL_DEPTH];

  assign eff_limit = (32'(limit_r) < POOL_DEPTH) ? CNT_W'(limit_r) : CNT_W'(POOL_DEPTH);
  assign room      = held_r < eff_limit;
  assign slot_ok   = 32'(slot_r) < 32'(held_r);

  always_comb begin
    cmd.width      = width_r;
    cmd.height     = height_r;
    cmd.fmt        = fmt_r;
    cmd.frame      = frame_r;
    cmd.idle_limit = idle_r;
    case (state_r)
      S_EVAL:  cmd.op = OP_EVAL;
      S_ACQ:   cmd.op = OP_ACQUIRE;
      S_REL:   cmd.op = OP_RELEASE;
      S_SHIFT: cmd.op = hole_any ? OP_SHIFT : OP_HOLD;
      default: cmd.op = OP_HOLD;
    endcase
  end

  always_comb begin
    hit_idx  = '0;
    busy_cnt = '0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      if (first[i]) hit_idx = hit_idx | IDX_W'(i);
      busy_cnt = busy_cnt + CNT_W'(ent[i].busy & in_pool[i]);
    end
  end

  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
    assign in_pool[i] = 32'(held_r) > i;
    assign first[i]   = hit_seen[i+1] & ~hit_seen[i];
    assign sel_wr[i]  = ((state_r == S_ACQ) & ~hit_any & room & (32'(held_r) == i)) |
                        ((state_r == S_REL) & slot_ok & (32'(slot_r) == i));
    if (i == POOL_DEPTH - 1) begin : g_last
      assign nb[i] = '0;
    end else begin : g_mid
      assign nb[i] = ent[i+1];
    end

    mrp_cell u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .in_pool      (in_pool[i]),
      .sel_wr       (sel_wr[i]),
      .hit_seen_in  (hit_seen[i]),
      .hole_seen_in (hole_seen[i]),
      .nb_in        (nb[i]),
      .ent_out      (ent[i]),
      .hit_seen_out (hit_seen[i+1]),
      .hole_seen_out(hole_seen[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      acq_r       <= '0;
      hit_r       <= '0;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
      idle_r      <= IDLE_RESET;
    end else begin
      out_valid_r <= 1'b0;
      if (psel && penable && pwrite) begin
        if (paddr[REG_SEL_BIT] == REG_POOL_LIMIT) limit_r <= pwdata[LIMIT_W-1:0];
        else idle_r <= pwdata[IDLE_W-1:0];
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            mode_r    <= in_mode;
            width_r   <= in_req_width;
            height_r  <= in_req_height;
            fmt_r     <= in_req_format;
            slot_r    <= in_slot;
            frame_r   <= in_frame_number;
            removed_r <= '0;
            index_r   <= '0;
            state_r   <= S_EVAL;
          end
        end
        S_EVAL: begin
          case (mode_r)
            MODE_ACQUIRE: state_r <= S_ACQ;
            MODE_RELEASE: state_r <= S_REL;
            MODE_CLEANUP: state_r <= S_SHIFT;
            default: begin
              status_r <= ST_IGNORED;
              state_r  <= S_FIN;
            end
          endcase
        end
        S_ACQ: begin
          acq_r <= acq_r + 1'b1;
          if (hit_any) begin
            hit_r    <= hit_r + 1'b1;
            status_r <= ST_HIT;
            index_r  <= hit_idx;
          end else if (room) begin
            held_r   <= held_r + 1'b1;
            status_r <= ST_NEW;
            index_r  <= held_r[IDX_W-1:0];
          end else begin
            status_r <= ST_FULL;
          end
          state_r <= S_FIN;
        end
        S_REL: begin
          status_r <= slot_ok ? ST_RELEASED : ST_IGNORED;
          state_r  <= S_FIN;
        end
        S_SHIFT: begin
          if (hole_any) begin
            held_r    <= held_r - 1'b1;
            removed_r <= removed_r + 1'b1;
          end else begin
            status_r <= ST_CLEANED;
            state_r  <= S_FIN;
          end
        end
        S_FIN: begin
          out_valid_r   <= 1'b1;
          out_status_r  <= status_r;
          out_index_r   <= OUT_IDX_W'(index_r);
          out_entry_r   <= OUT_CNT_W'(held_r);
          out_busy_r    <= OUT_CNT_W'(busy_cnt);
          out_acq_r     <= acq_r;
          out_hit_r     <= hit_r;
          out_removed_r <= OUT_CNT_W'(removed_r);
          state_r       <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy              = state_r != S_IDLE;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot_index    = out_index_r;
  assign out_entry_count   = out_entry_r;
  assign out_busy_count    = out_busy_r;
  assign out_acquire_total = out_acq_r;
  assign out_hit_total     = out_hit_r;
  assign out_removed_count = out_removed_r;

  assign pready = 1'b1;
  assign prdata = (paddr[REG_SEL_BIT] == REG_IDLE_LIMIT) ? DATA_W'(idle_r) : DATA_W'(limit_r);

endmodule

/* rtl/mrp_checker.sv */
module mrp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [mrp_pkg::STATUS_W-1:0]  out_status,
  input logic [mrp_pkg::OUT_CNT_W-1:0] out_entry_count,
  input logic [mrp_pkg::OUT_CNT_W-1:0] out_busy_count,
  input logic [mrp_pkg::OUT_CNT_W-1:0] out_removed_count
);
  import mrp_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted word");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_busy_le_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_busy_count <= out_entry_count))
    else $error("busy count exceeds entry count");

  a_removed_only_cleanup: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_CLEANED)) |-> (out_removed_count == '0))
    else $error("removed count set outside cleanup");

endmodule

bind matching_resource_pool_top mrp_checker u_mrp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_entry_count  (out_entry_count),
  .out_busy_count   (out_busy_count),
  .out_removed_count(out_removed_count)
);
